// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  // Field widths of one request and one response.
  localparam int OPCODE_W    = 1;
  localparam int TAG_W       = 8;
  localparam int PRI_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  // Default number of entries held by the queue.
  localparam int DEF_QUEUE_DEPTH = 16;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_INSERT  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_EXECUTE = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller states.
  typedef enum logic {
    CS_IDLE,
    CS_WORK
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // load the request registers
    logic execute;   // apply the held request and load the response register
    logic take;      // the response register is being transferred out
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic result_pending;  // the response register holds an untaken result
  } spq_stat_t;

endpackage

// ----- rtl/spq_req_if.sv -----
interface spq_req_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [TAG_W-1:0]    process_tag;
  logic [PRI_W-1:0]    priority_level;

  modport source (output valid, output opcode, output process_tag, output priority_level,
                  input ready);
  modport sink   (input valid, input opcode, input process_tag, input priority_level,
                  output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
interface spq_rsp_if;
  import spq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    served_tag;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output served_tag, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input served_tag, input occupancy,
                  output ready);
endinterface

// ----- rtl/spq_datapath.sv -----
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spq_pkg::spq_cmd_t             cmd,
  output spq_pkg::spq_stat_t            stat,
  input  logic [spq_pkg::OPCODE_W-1:0]  opcode,
  input  logic [spq_pkg::TAG_W-1:0]     process_tag,
  input  logic [spq_pkg::PRI_W-1:0]     priority_level,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::TAG_W-1:0]     served_tag,
  output logic [spq_pkg::OCC_W-1:0]     occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Held request.
  logic [OPCODE_W-1:0] op_q;
  logic [TAG_W-1:0]    tag_q;
  logic [PRI_W-1:0]    pri_q;

  // Sorted cells; cells below count are valid, in non-decreasing priority number.
  logic [PRI_W-1:0] slot_pri      [QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag      [QUEUE_DEPTH];
  logic [PRI_W-1:0] slot_pri_next [QUEUE_DEPTH];
  logic [TAG_W-1:0] slot_tag_next [QUEUE_DEPTH];
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic [QUEUE_DEPTH-1:0] gt;
  logic                   is_full;
  logic                   is_empty;
  logic                   apply_ins;
  logic                   apply_pop;

  logic [STATUS_W-1:0] status_next;
  logic [TAG_W-1:0]    served_next;
  logic                result_valid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      tag_q <= process_tag;
      pri_q <= priority_level;
    end
  end

  assign is_full   = (count == CW'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);
  assign apply_ins = cmd.execute && (op_q == OP_INSERT) && !is_full;
  assign apply_pop = cmd.execute && (op_q == OP_EXECUTE) && !is_empty;

  // Every cell compares itself with the new priority at once. Because the
  // cells are sorted, gt is a run of zeros followed by ones over the valid part.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign gt[i] = (CW'(i) < count) && (slot_pri[i] > pri_q);

    always_comb begin
      slot_pri_next[i] = slot_pri[i];
      slot_tag_next[i] = slot_tag[i];
      if (op_q == OP_INSERT) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          slot_pri_next[i] = slot_pri[(i > 0) ? i - 1 : 0];
          slot_tag_next[i] = slot_tag[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (count == CW'(i))) begin
          slot_pri_next[i] = pri_q;
          slot_tag_next[i] = tag_q;
        end
      end else if (i < QUEUE_DEPTH - 1) begin
        slot_pri_next[i] = slot_pri[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        slot_tag_next[i] = slot_tag[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (apply_ins || apply_pop) begin
        slot_pri[i] <= slot_pri_next[i];
        slot_tag[i] <= slot_tag_next[i];
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    served_next = '0;
    if (op_q == OP_INSERT) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next  = count - CW'(1);
        served_next = slot_tag[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status     <= status_next;
      served_tag <= served_next;
      occupancy  <= OCC_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.execute) begin
      result_valid <= 1'b1;
    end else if (cmd.take) begin
      result_valid <= 1'b0;
    end
  end

  assign stat.result_pending = result_valid;

endmodule

// ----- rtl/spq_controller.sv -----
module spq_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                rsp_ready,
  input  spq_pkg::spq_stat_t  stat,
  output spq_pkg::spq_cmd_t   cmd
);
  import spq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A request may enter while the controller is idle and the response register is empty or emptying.
  assign req_ready = (state == CS_IDLE) && (!stat.result_pending || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (accept) begin
          state_next = CS_WORK;
        end
      end
      CS_WORK: begin
        state_next = CS_IDLE;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.take    = stat.result_pending && rsp_ready;
    unique case (state)
      CS_IDLE: begin
        cmd.capture = accept;
      end
      CS_WORK: begin
        cmd.execute = 1'b1;
      end
      default: begin
        cmd.execute = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/stable_priority_queue.sv -----
// Channel | Role  | Payload
// --------+-------+------------------------------------------------
// req     | sink  | opcode, process_tag, priority_level
// rsp     | source| status, served_tag, occupancy
//
// Each request is transferred into the request register while the controller is
// idle; in the work state every cell compares and shifts in parallel and the
// response register is loaded. The controller's two states keep a new request
// out while one is in work. Reset (rst, synchronous) empties the queue and
// clears any pending response. A stalled response is held, and the next request
// is still taken in the cycle in which that response is transferred.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  // Command and status between the sequencing logic and the queue storage.
  spq_cmd_t  cmd;
  spq_stat_t stat;

  // The controller decides when a request transfer happens and when the held
  // request is applied to the queue.
  spq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the sorted cells, the fill count and the response
  // register. An insert lands after every entry of lower or equal priority
  // number, so equal priorities leave in arrival order.
  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (req.opcode),
    .process_tag    (req.process_tag),
    .priority_level (req.priority_level),
    .status         (rsp.status),
    .served_tag     (rsp.served_tag),
    .occupancy      (rsp.occupancy)
  );

  // The response is valid for as long as the response register holds a result.
  assign rsp.valid = stat.result_pending;

endmodule

// ----- rtl/spq_checker.sv -----
module spq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::TAG_W-1:0]    served_tag,
  input logic [spq_pkg::OCC_W-1:0]    occupancy
);
  import spq_pkg::*;

  // An untaken response stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn before transfer");

  // Every request transfer yields a response once the held request has been applied.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("no response after request transfer");

  // The queue works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // A failing status never returns a tag.
  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> served_tag == '0)
    else $error("tag returned with a failing status");

  // An empty report comes only from an empty queue.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> occupancy == '0)
    else $error("empty status with entries held");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .served_tag (rsp.served_tag),
  .occupancy  (rsp.occupancy)
);

// ----- tb/sv/tb_stable_priority_queue.sv -----
module tb_stable_priority_queue;
  import spq_pkg::*;

  // The block is built at its default depth, which the occupancy field can show
  // in full without wrapping.
  localparam int DEPTH = DEF_QUEUE_DEPTH;

  // Number of random requests after the directed opening.
  localparam int RANDOM_REQUESTS = 850;

  // The watchdog limit covers, for every request, the sender gap, the time inside
  // the block and the receiver stall, with a wide margin.
  localparam int CYCLE_LIMIT = 300000;

  // One request as the sender plans it. Where wait_for_drain is set, the sender
  // holds this request back until every earlier response has been transferred.
  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [TAG_W-1:0]    process_tag;
    logic [PRI_W-1:0]    priority_level;
    bit                  wait_for_drain;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    served_tag;
    logic [OCC_W-1:0]    occupancy;
  } response_t;

  logic clk;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_priority_queue #(
    .QUEUE_DEPTH (DEPTH)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests still to be offered, and responses the queue model says are owed.
  request_t  planned_requests[$];
  response_t owed_responses[$];

  // The testbench's own copy of the queue contents, kept sorted from slot 0.
  logic [PRI_W-1:0] model_priority[DEPTH];
  logic [TAG_W-1:0] model_tag[DEPTH];
  int               model_count;

  request_t current_request;
  int       planned_count;
  int       accepted_count;
  int       mismatch_count;
  int       cycle_count;

  // Sender burst and gap counters, and the receiver's stall pattern.
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_mode_left;

  always #10 clk = ~clk;

  // Applies one request to the queue model and returns the response it owes.
  // An insert goes after every entry of lower or equal priority number, so equal
  // priorities stay in arrival order; a full queue drops the insert, and an
  // empty queue answers an execute with the empty status.
  function automatic response_t apply_request(request_t r);
    response_t resp;
    int        slot;
    bit        found;
    resp.status     = ST_OK;
    resp.served_tag = '0;
    if (r.opcode == OP_INSERT) begin
      if (model_count >= DEPTH) begin
        resp.status = ST_FULL;
      end else begin
        slot  = model_count;
        found = 1'b0;
        for (int i = 0; i < model_count; i++) begin
          if (!found && model_priority[i] > r.priority_level) begin
            slot  = i;
            found = 1'b1;
          end
        end
        for (int i = model_count; i > slot; i--) begin
          model_priority[i] = model_priority[i-1];
          model_tag[i]      = model_tag[i-1];
        end
        model_priority[slot] = r.priority_level;
        model_tag[slot]      = r.process_tag;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        resp.status = ST_EMPTY;
      end else begin
        resp.served_tag = model_tag[0];
        for (int i = 0; i + 1 < model_count; i++) begin
          model_priority[i] = model_priority[i+1];
          model_tag[i]      = model_tag[i+1];
        end
        model_count--;
      end
    end
    resp.occupancy = model_count[OCC_W-1:0];
    return resp;
  endfunction

  task automatic report_mismatch(input string what, input int wanted, input int seen);
    $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_count, what, wanted,
             seen);
    mismatch_count++;
  endtask

  task automatic plan_request(input logic [OPCODE_W-1:0] op, input int tag, input int pri,
                              input bit drain);
    request_t r;
    r.opcode         = op;
    r.process_tag    = tag[TAG_W-1:0];
    r.priority_level = pri[PRI_W-1:0];
    r.wait_for_drain = drain;
    planned_requests.push_back(r);
    planned_count++;
  endtask

  // Sender. A request stays on the channel until its transfer; only when the
  // channel is free does the sender choose between a gap and the next request.
  // Every request is handed to the queue model at the edge of its transfer.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        owed_responses.push_back(apply_request(current_request));
        accepted_count++;
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (planned_requests.size() != 0 &&
                     !(planned_requests[0].wait_for_drain && owed_responses.size() != 0)) begin
          current_request = planned_requests.pop_front();
          req_ch.valid          <= 1'b1;
          req_ch.opcode         <= current_request.opcode;
          req_ch.process_tag    <= current_request.process_tag;
          req_ch.priority_level <= current_request.priority_level;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // New burst: a long one now and then, so that some stretches run
            // with no idling at all; the gaps shift the phase against the
            // block's alternation of its idle and work states.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Its ready follows a pattern of its own, drawn anew whenever the
  // current one runs out: always ready, random, mostly stalled, or a fixed rhythm.
  // Each transfer is checked field by field against the oldest owed response.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_responses.size() == 0) begin
          report_mismatch("unexpected response, status", -1, rsp_ch.status);
        end else begin
          if (rsp_ch.status !== owed_responses[0].status)
            report_mismatch("status", owed_responses[0].status, rsp_ch.status);
          if (rsp_ch.served_tag !== owed_responses[0].served_tag)
            report_mismatch("served_tag", owed_responses[0].served_tag, rsp_ch.served_tag);
          if (rsp_ch.occupancy !== owed_responses[0].occupancy)
            report_mismatch("occupancy", owed_responses[0].occupancy, rsp_ch.occupancy);
          void'(owed_responses.pop_front());
        end
      end
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 3);
        stall_mode_left = $urandom_range(10, 60);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0: begin
          rsp_ch.ready <= 1'b1;
        end
        1: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_ch.ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          rsp_ch.ready <= (cycle_count % 3 != 0);
        end
      endcase
    end
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL stable_priority_queue");
      $finish;
    end
  end

  initial begin
    int seg_len;
    int insert_pct;
    int pri_mode;
    int pri;
    int random_planned;
    bit drain;

    clk                   = 1'b0;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_INSERT;
    req_ch.process_tag    = '0;
    req_ch.priority_level = '0;
    rsp_ch.ready          = 1'b0;
    model_count           = 0;
    planned_count         = 0;
    accepted_count        = 0;
    mismatch_count        = 0;
    cycle_count           = 0;
    burst_left            = 0;
    gap_left              = 0;
    stall_mode            = 0;
    stall_mode_left       = 0;

    // Directed opening. An execute on the empty queue comes first, then the
    // queue is filled with extreme tags and priorities, including runs of equal
    // priority whose order of service must follow arrival. One more insert hits
    // the full queue and is dropped; a few executes then take from the front.
    plan_request(OP_EXECUTE, 8'hff, 8'hff, 1'b0);
    plan_request(OP_INSERT, 8'h00, 8'hff, 1'b0);
    plan_request(OP_INSERT, 8'hff, 8'h00, 1'b0);
    plan_request(OP_INSERT, 8'h11, 8'h00, 1'b0);
    plan_request(OP_INSERT, 8'h22, 8'h80, 1'b0);
    plan_request(OP_INSERT, 8'h33, 8'hff, 1'b0);
    plan_request(OP_INSERT, 8'h44, 8'h7f, 1'b0);
    plan_request(OP_INSERT, 8'h55, 8'h80, 1'b0);
    plan_request(OP_INSERT, 8'h66, 8'h01, 1'b0);
    plan_request(OP_INSERT, 8'h77, 8'hfe, 1'b0);
    plan_request(OP_INSERT, 8'h88, 8'h00, 1'b0);
    plan_request(OP_INSERT, 8'h99, 8'h55, 1'b0);
    plan_request(OP_INSERT, 8'haa, 8'haa, 1'b0);
    plan_request(OP_INSERT, 8'hbb, 8'hff, 1'b0);
    plan_request(OP_INSERT, 8'hcc, 8'h80, 1'b0);
    plan_request(OP_INSERT, 8'hdd, 8'h01, 1'b0);
    plan_request(OP_INSERT, 8'hee, 8'h00, 1'b0);
    plan_request(OP_INSERT, 8'h5a, 8'h00, 1'b0);
    plan_request(OP_EXECUTE, 8'h00, 8'h00, 1'b0);
    plan_request(OP_EXECUTE, 8'ha5, 8'h5a, 1'b0);
    plan_request(OP_EXECUTE, 8'h00, 8'hff, 1'b0);
    plan_request(OP_EXECUTE, 8'hff, 8'h00, 1'b0);

    // Random part, in segments that lean towards inserts, balance, or executes,
    // so the queue swings between full and empty many times. Priorities come
    // from a narrow range (many ties), the full range, or the extremes. The
    // first random segment, and some later ones, start only once every earlier
    // response has been transferred.
    random_planned = 0;
    while (random_planned < RANDOM_REQUESTS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: insert_pct = 85;
        1: insert_pct = 50;
        default: insert_pct = 15;
      endcase
      pri_mode = $urandom_range(0, 2);
      drain    = (random_planned == 0) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len && random_planned < RANDOM_REQUESTS; k++) begin
        case (pri_mode)
          0: pri = $urandom_range(0, 3);
          1: pri = $urandom_range(0, 255);
          default: begin
            case ($urandom_range(0, 3))
              0: pri = 0;
              1: pri = 1;
              2: pri = 254;
              default: pri = 255;
            endcase
          end
        endcase
        plan_request(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_EXECUTE,
                     $urandom_range(0, 255), pri, drain && (k == 0));
        random_planned++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != planned_count) @(posedge clk);
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS stable_priority_queue");
    end else begin
      $display("FAIL stable_priority_queue");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_datapath.sv
rtl/spq_controller.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
tb/sv/tb_stable_priority_queue.sv
